// ===== design/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel pipeline.
package rgbhsv_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIV_STEPS = 8;

  localparam logic [PIX_W-1:0] HUE_BASE_GREEN = 8'd60;
  localparam logic [PIX_W-1:0] HUE_BASE_BLUE  = 8'd120;
  localparam logic [PIX_W-1:0] HUE_WRAP       = 8'd180;

  // Channel that holds the maximum; red wins ties, then green.
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  typedef struct packed {
    logic [PIX_W-1:0] max_v;
    logic [PIX_W-1:0] min_v;
    logic signed [PIX_W:0] diff;
    sector_t          sector;
  } sort_t;

  // Restoring divider lane: partial remainder, numerator bits still to
  // shift in, quotient bits produced so far.
  typedef struct packed {
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] q;
  } div_t;

  typedef struct packed {
    div_t             hue_div;
    div_t             sat_div;
    logic [PIX_W-1:0] delta;
    logic [PIX_W-1:0] bright;
    logic             neg;
    sector_t          sector;
  } work_t;

endpackage

// ===== design/rgbhsv_sort.sv =====
// First stage: channel maximum, minimum, sector and signed hue difference.
module rgbhsv_sort (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  input  logic [rgbhsv_pkg::PIX_W-1:0]      up_blue,
  input  logic [rgbhsv_pkg::PIX_W-1:0]      up_green,
  input  logic [rgbhsv_pkg::PIX_W-1:0]      up_red,
  output logic                              up_ready,
  output logic                              dn_valid,
  output rgbhsv_pkg::sort_t                 dn_data,
  input  logic                              dn_ready
);

  logic              valid_r;
  rgbhsv_pkg::sort_t data_r;
  rgbhsv_pkg::sort_t data_nxt;

  logic signed [rgbhsv_pkg::PIX_W:0] b_s;
  logic signed [rgbhsv_pkg::PIX_W:0] g_s;
  logic signed [rgbhsv_pkg::PIX_W:0] r_s;

  assign b_s = $signed({1'b0, up_blue});
  assign g_s = $signed({1'b0, up_green});
  assign r_s = $signed({1'b0, up_red});

  always_comb begin
    data_nxt = '0;
    if (up_red >= up_green && up_red >= up_blue) begin
      data_nxt.sector = rgbhsv_pkg::SEC_RED;
      data_nxt.max_v  = up_red;
      data_nxt.diff   = g_s - b_s;
    end else if (up_green >= up_blue) begin
      data_nxt.sector = rgbhsv_pkg::SEC_GREEN;
      data_nxt.max_v  = up_green;
      data_nxt.diff   = b_s - r_s;
    end else begin
      data_nxt.sector = rgbhsv_pkg::SEC_BLUE;
      data_nxt.max_v  = up_blue;
      data_nxt.diff   = r_s - g_s;
    end
    data_nxt.min_v = up_red;
    if (up_green < data_nxt.min_v) data_nxt.min_v = up_green;
    if (up_blue < data_nxt.min_v)  data_nxt.min_v = up_blue;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/rgbhsv_prep.sv =====
// Second stage: delta, hue sign and the two dividend words.
module rgbhsv_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  rgbhsv_pkg::sort_t    up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output rgbhsv_pkg::work_t    dn_data,
  input  logic                 dn_ready
);

  logic              valid_r;
  rgbhsv_pkg::work_t data_r;
  rgbhsv_pkg::work_t data_nxt;

  logic [rgbhsv_pkg::PIX_W-1:0]   delta;
  logic                           neg;
  logic [rgbhsv_pkg::PIX_W:0]     diff_u;
  logic [rgbhsv_pkg::PIX_W-1:0]   abs_d;
  logic [2*rgbhsv_pkg::PIX_W-1:0] num_h;
  logic [2*rgbhsv_pkg::PIX_W-1:0] num_s;

  always_comb begin
    delta  = up_data.max_v - up_data.min_v;
    neg    = up_data.diff[rgbhsv_pkg::PIX_W];
    diff_u = neg ? (9'd0 - $unsigned(up_data.diff)) : $unsigned(up_data.diff);
    abs_d  = diff_u[rgbhsv_pkg::PIX_W-1:0];
    // 30*|d| and 255*delta as shift-and-subtract
    num_h  = ({8'd0, abs_d} << 5) - ({8'd0, abs_d} << 1);
    num_s  = {delta, 8'd0} - {8'd0, delta};

    data_nxt            = '0;
    data_nxt.hue_div.p  = num_h[15:8];
    data_nxt.hue_div.n  = num_h[7:0];
    data_nxt.sat_div.p  = num_s[15:8];
    data_nxt.sat_div.n  = num_s[7:0];
    data_nxt.delta      = delta;
    data_nxt.bright     = up_data.max_v;
    data_nxt.neg        = neg;
    data_nxt.sector     = up_data.sector;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/rgbhsv_div_step.sv =====
// One restoring-division step for both the hue and saturation lanes.
module rgbhsv_div_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  rgbhsv_pkg::work_t    up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output rgbhsv_pkg::work_t    dn_data,
  input  logic                 dn_ready
);

  logic              valid_r;
  rgbhsv_pkg::work_t data_r;
  rgbhsv_pkg::work_t data_nxt;

  function automatic rgbhsv_pkg::div_t div_step(input rgbhsv_pkg::div_t d,
                                                input logic [rgbhsv_pkg::PIX_W-1:0] den);
    rgbhsv_pkg::div_t      r;
    logic [rgbhsv_pkg::PIX_W:0] p_sh;
    logic [rgbhsv_pkg::PIX_W:0] p_sub;
    p_sh  = {d.p, d.n[rgbhsv_pkg::PIX_W-1]};
    p_sub = p_sh - {1'b0, den};
    r.n   = {d.n[rgbhsv_pkg::PIX_W-2:0], 1'b0};
    if (p_sh >= {1'b0, den}) begin
      r.p = p_sub[rgbhsv_pkg::PIX_W-1:0];
      r.q = {d.q[rgbhsv_pkg::PIX_W-2:0], 1'b1};
    end else begin
      r.p = p_sh[rgbhsv_pkg::PIX_W-1:0];
      r.q = {d.q[rgbhsv_pkg::PIX_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    data_nxt         = up_data;
    data_nxt.hue_div = div_step(up_data.hue_div, up_data.delta);
    data_nxt.sat_div = div_step(up_data.sat_div, up_data.bright);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Partial remainders stay below their divisors.
  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.bright == '0 || data_r.sat_div.p < data_r.bright))
    else $error("saturation remainder not below max");

  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.delta == '0 || data_r.hue_div.p < data_r.delta))
    else $error("hue remainder not below delta");

endmodule

// ===== design/rgbhsv_finish.sv =====
// Last stage: floor correction, hue offset and the output register.
module rgbhsv_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  input  rgbhsv_pkg::work_t             up_data,
  output logic                          up_ready,
  output logic                          dn_valid,
  output logic [rgbhsv_pkg::PIX_W-1:0]  dn_hue,
  output logic [rgbhsv_pkg::PIX_W-1:0]  dn_saturation,
  output logic [rgbhsv_pkg::PIX_W-1:0]  dn_brightness,
  input  logic                          dn_ready
);

  logic                         valid_r;
  logic [rgbhsv_pkg::PIX_W-1:0] hue_r;
  logic [rgbhsv_pkg::PIX_W-1:0] sat_r;
  logic [rgbhsv_pkg::PIX_W-1:0] bright_r;
  logic [rgbhsv_pkg::PIX_W-1:0] hue_nxt;
  logic [rgbhsv_pkg::PIX_W-1:0] sat_nxt;
  logic [rgbhsv_pkg::PIX_W-1:0] mag;
  logic [rgbhsv_pkg::PIX_W-1:0] base;

  always_comb begin
    // Negative quotients round away from zero: add one on a nonzero remainder.
    mag = up_data.hue_div.q;
    if (up_data.neg && up_data.hue_div.p != '0) begin
      mag = up_data.hue_div.q + 8'd1;
    end
    unique case (up_data.sector)
      rgbhsv_pkg::SEC_RED:   base = up_data.neg ? rgbhsv_pkg::HUE_WRAP : '0;
      rgbhsv_pkg::SEC_GREEN: base = rgbhsv_pkg::HUE_BASE_GREEN;
      rgbhsv_pkg::SEC_BLUE:  base = rgbhsv_pkg::HUE_BASE_BLUE;
      default:               base = '0;
    endcase
    if (up_data.delta == '0) begin
      hue_nxt = '0;
    end else if (up_data.neg) begin
      hue_nxt = base - mag;
    end else begin
      hue_nxt = base + mag;
    end
    sat_nxt = (up_data.bright == '0) ? '0 : up_data.sat_div.q;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= up_data.bright;
    end
  end

  assign dn_valid      = valid_r;
  assign dn_hue        = hue_r;
  assign dn_saturation = sat_r;
  assign dn_brightness = bright_r;

endmodule

// ===== design/rgb_to_hsv_8bit_unit.sv =====
// Pipeline: sort, prep, eight divider steps, finish, each stage one
//   register.
// Throughput: one pixel per cycle while out_stall is low; the eight-step restoring divider is fully
//   pipelined, one quotient bit per stage for both hue and saturation.
// Reset: synchronous active-low rst_n clears every stage valid bit; data
//   registers are not reset.
module rgb_to_hsv_8bit_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_blue,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_green,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_red,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgbhsv_pkg::PIX_W-1:0]  out_hue,
  output logic [rgbhsv_pkg::PIX_W-1:0]  out_saturation,
  output logic [rgbhsv_pkg::PIX_W-1:0]  out_brightness
);

  logic              sort_ready;
  logic              sort_valid;
  rgbhsv_pkg::sort_t sort_data;
  logic              prep_ready;

  logic              step_valid [rgbhsv_pkg::DIV_STEPS+1];
  logic              step_ready [rgbhsv_pkg::DIV_STEPS+1];
  rgbhsv_pkg::work_t step_data  [rgbhsv_pkg::DIV_STEPS+1];

  assign in_stall = !sort_ready;

  rgbhsv_sort u_sort (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_blue  (in_blue),
    .up_green (in_green),
    .up_red   (in_red),
    .up_ready (sort_ready),
    .dn_valid (sort_valid),
    .dn_data  (sort_data),
    .dn_ready (prep_ready)
  );

  rgbhsv_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sort_valid),
    .up_data  (sort_data),
    .up_ready (prep_ready),
    .dn_valid (step_valid[0]),
    .dn_data  (step_data[0]),
    .dn_ready (step_ready[0])
  );

  for (genvar i = 0; i < rgbhsv_pkg::DIV_STEPS; i++) begin : g_div
    rgbhsv_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (step_valid[i]),
      .up_data  (step_data[i]),
      .up_ready (step_ready[i]),
      .dn_valid (step_valid[i+1]),
      .dn_data  (step_data[i+1]),
      .dn_ready (step_ready[i+1])
    );
  end

  rgbhsv_finish u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (step_valid[rgbhsv_pkg::DIV_STEPS]),
    .up_data       (step_data[rgbhsv_pkg::DIV_STEPS]),
    .up_ready      (step_ready[rgbhsv_pkg::DIV_STEPS]),
    .dn_valid      (out_valid),
    .dn_hue        (out_hue),
    .dn_saturation (out_saturation),
    .dn_brightness (out_brightness),
    .dn_ready      (!out_stall)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue <= 8'd179)
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> out_saturation == '0)
    else $error("black pixel with nonzero saturation");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> out_hue == '0)
    else $error("gray pixel with nonzero hue");

endmodule

// ===== sim/hsv_checker.sv =====
// Checker for the RGB to HSV unit: predicts each pixel's HSV and compares results in order.
module hsv_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_blue,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_green,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_red,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rgbhsv_pkg::PIX_W-1:0] out_hue,
  input  logic [rgbhsv_pkg::PIX_W-1:0] out_saturation,
  input  logic [rgbhsv_pkg::PIX_W-1:0] out_brightness,
  output int unsigned                  error_count,
  output int unsigned                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEXTANT_SCALE = 30;
  localparam int SAT_SCALE     = 255;

  typedef logic [rgbhsv_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t hue;
    pix_t sat;
    pix_t bright;
  } hsv_pixel_t;

  hsv_pixel_t  hsv_expected_q[$];
  int unsigned mismatch_count = 0;

  assign error_count = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Quotient rounded toward minus infinity; den is always positive here.
  function automatic int floor_quot(input int num, input int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic hsv_pixel_t rgb_to_hsv_predict(input pix_t b,
                                                    input pix_t g,
                                                    input pix_t r);
    int         bi, gi, ri, hi, lo, span, h, sq;
    hsv_pixel_t res;
    bi = int'(b);
    gi = int'(g);
    ri = int'(r);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    span = hi - lo;
    h = 0;
    // Red wins ties over green and blue, green wins over blue.
    if (span != 0) begin
      if (hi == ri) begin
        h = floor_quot(SEXTANT_SCALE * (gi - bi), span);
        if (h < 0) h += int'(rgbhsv_pkg::HUE_WRAP);
      end else if (hi == gi) begin
        h = int'(rgbhsv_pkg::HUE_BASE_GREEN)
            + floor_quot(SEXTANT_SCALE * (bi - ri), span);
      end else begin
        h = int'(rgbhsv_pkg::HUE_BASE_BLUE)
            + floor_quot(SEXTANT_SCALE * (ri - gi), span);
      end
    end
    sq = (hi != 0) ? (SAT_SCALE * span) / hi : 0;
    res.hue    = h[rgbhsv_pkg::PIX_W-1:0];
    res.sat    = sq[rgbhsv_pkg::PIX_W-1:0];
    res.bright = hi[rgbhsv_pkg::PIX_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    hsv_pixel_t want_px;
    if (rst_n) begin
      if (in_valid && !in_stall)
        hsv_expected_q = {hsv_expected_q, rgb_to_hsv_predict(in_blue, in_green, in_red)};
      if (out_valid && !out_stall) begin
        if (hsv_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result h=%0d s=%0d v=%0d",
                                    out_hue, out_saturation, out_brightness));
        end else begin
          want_px = hsv_expected_q.pop_front();
          if (out_hue !== want_px.hue)
            report_mismatch($sformatf("hue %0d, expected %0d", out_hue, want_px.hue));
          if (out_saturation !== want_px.sat)
            report_mismatch($sformatf("saturation %0d, expected %0d",
                                      out_saturation, want_px.sat));
          if (out_brightness !== want_px.bright)
            report_mismatch($sformatf("brightness %0d, expected %0d",
                                      out_brightness, want_px.bright));
        end
      end
    end
    pending_count <= hsv_expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the RGB to HSV unit: clock, reset, pixel stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [rgbhsv_pkg::PIX_W-1:0] pix_t;

  localparam int RANDOM_PIXELS = 930;
  localparam int TAIL_PIXELS   = 120;
  localparam int DRAIN_CYCLES  = 24;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  pix_t             in_blue;
  pix_t             in_green;
  pix_t             in_red;
  logic             out_valid;
  logic             out_stall;
  pix_t             out_hue;
  pix_t             out_saturation;
  pix_t             out_brightness;
  int unsigned      error_count;
  int unsigned      pending_count;
  bit               quiet_tail = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rgb_to_hsv_8bit_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  hsv_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .error_count    (error_count),
    .pending_count  (pending_count)
  );

  // Present one pixel, hold it until the transfer, then maybe pause.
  task automatic send_pixel(input pix_t b,
                            input pix_t g,
                            input pix_t r);
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic random_pixel(output pix_t b,
                              output pix_t g,
                              output pix_t r);
    int top, base, pick;
    pick = $urandom_range(0, 9);
    b = pix_t'($urandom_range(0, 255));
    g = pix_t'($urandom_range(0, 255));
    r = pix_t'($urandom_range(0, 255));
    case (pick)
      4: begin
        g = b;
        r = b;
      end
      5, 6: begin
        // one channel dominant, the others at or below it
        top = $urandom_range(1, 255);
        b = pix_t'($urandom_range(0, top));
        g = pix_t'($urandom_range(0, top));
        r = pix_t'($urandom_range(0, top));
        case ($urandom_range(0, 2))
          0: r = pix_t'(top);
          1: g = pix_t'(top);
          default: b = pix_t'(top);
        endcase
      end
      7: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = r;
          default: b = g;
        endcase
      end
      8: begin
        // near gray: spans of a few codes stress the divider
        base = $urandom_range(3, 252);
        b = pix_t'(base + int'($urandom_range(0, 6)) - 3);
        g = pix_t'(base + int'($urandom_range(0, 6)) - 3);
        r = pix_t'(base + int'($urandom_range(0, 6)) - 3);
      end
      9: begin
        b = pix_t'($urandom_range(0, 3));
        g = pix_t'($urandom_range(0, 3));
        r = pix_t'($urandom_range(0, 3));
      end
      default: ;
    endcase
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    pix_t b, g, r;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_blue  <= '0;
    in_green <= '0;
    in_red   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corners: arguments are blue, green, red
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // mid gray
    send_pixel(8'd0,   8'd0,   8'd255);  // pure red
    send_pixel(8'd0,   8'd255, 8'd0);    // pure green
    send_pixel(8'd255, 8'd0,   8'd0);    // pure blue
    send_pixel(8'd0,   8'd255, 8'd255);  // red ties green
    send_pixel(8'd255, 8'd0,   8'd255);  // red ties blue, hue wraps
    send_pixel(8'd255, 8'd255, 8'd0);    // green ties blue
    send_pixel(8'd1,   8'd0,   8'd255);  // small negative red hue
    send_pixel(8'd0,   8'd1,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd1);    // max of one
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd254);  // green over blue, span one
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd128, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd254, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd170, 8'd85,  8'd85);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS - TAIL_PIXELS) quiet_tail = 1'b1;
      random_pixel(b, g, r);
      send_pixel(b, g, r);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
